// File: hw/rtl/lpsc_pkg.sv
// ----------------------------------------------------------------------------
// lpsc_pkg
// Shared types and constants for the length-prefix to start-code converter.
// ----------------------------------------------------------------------------
`default_nettype none

package lpsc_pkg;

    // Width of the buffer byte counter (8..32).
    localparam int unsigned LENGTH_BITS = 24;

    // Width of the buffer length field on the input bus.
    localparam int unsigned BUF_LEN_W = 24;
    // Width of a unit length taken from the 4-byte prefix.
    localparam int unsigned UNIT_LEN_W = 32;
    // Prefix bytes per unit.
    localparam int unsigned PREFIX_BYTES = 4;

    typedef enum logic [1:0] {
        PH_DISCARD = 2'd0,
        PH_PREFIX  = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    // Result burst handed from the parser to the output stage.
    typedef struct packed {
        logic       emit;     // this item yields results
        logic       is_start; // four start-code beats, else one data beat
        logic [7:0] data;     // payload byte
    } t_burst;

endpackage

`default_nettype wire

// File: hw/rtl/lpsc_parser.sv
// ----------------------------------------------------------------------------
// lpsc_parser
// Per-byte parse state: prefix gathering, unit and buffer byte counts.
// ----------------------------------------------------------------------------
`default_nettype none

module lpsc_parser (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_accept,
    input  wire logic [7:0]                       i_data_byte,
    input  wire logic                             i_first_of_buffer,
    input  wire logic [lpsc_pkg::BUF_LEN_W-1:0]   i_buffer_length,
    output lpsc_pkg::t_burst                      o_burst
);

    lpsc_pkg::t_phase                        r_phase, n_phase;
    logic [1:0]                              r_prefix_count, n_prefix_count;
    logic [23:0]                             r_prefix_shift, n_prefix_shift;
    logic [lpsc_pkg::UNIT_LEN_W-1:0]         r_payload_left, n_payload_left;
    logic [lpsc_pkg::LENGTH_BITS-1:0]        r_buffer_left, n_buffer_left;

    // State as seen after a buffer start restarts conversion.
    lpsc_pkg::t_phase                        e_phase;
    logic [1:0]                              e_count;
    logic [23:0]                             e_shift;
    logic [lpsc_pkg::UNIT_LEN_W-1:0]         e_payload;
    logic [lpsc_pkg::LENGTH_BITS-1:0]        e_buffer;
    logic [lpsc_pkg::LENGTH_BITS-1:0]        buffer_dec;
    logic [lpsc_pkg::UNIT_LEN_W-1:0]         unit_len;
    logic                                    short_tail;
    logic                                    overrun;

    always_comb begin
        e_phase   = i_first_of_buffer ? lpsc_pkg::PH_PREFIX : r_phase;
        e_count   = i_first_of_buffer ? 2'd0 : r_prefix_count;
        e_shift   = i_first_of_buffer ? 24'd0 : r_prefix_shift;
        e_payload = i_first_of_buffer ? '0 : r_payload_left;
        e_buffer  = i_first_of_buffer ? lpsc_pkg::LENGTH_BITS'(i_buffer_length)
                                      : r_buffer_left;
        buffer_dec = e_buffer - lpsc_pkg::LENGTH_BITS'(1);
        unit_len   = {e_shift, i_data_byte};
        short_tail = (e_count == 2'd0) &&
                     (e_buffer < lpsc_pkg::LENGTH_BITS'(lpsc_pkg::PREFIX_BYTES));
        overrun    = unit_len > lpsc_pkg::UNIT_LEN_W'(buffer_dec);
    end

    // Next state.
    always_comb begin
        n_phase        = e_phase;
        n_prefix_count = e_count;
        n_prefix_shift = e_shift;
        n_payload_left = e_payload;
        n_buffer_left  = e_buffer;
        unique case (e_phase)
            lpsc_pkg::PH_PREFIX: begin
                if (short_tail) begin
                    n_phase = lpsc_pkg::PH_DISCARD;
                end else begin
                    n_buffer_left = buffer_dec;
                    if (e_count != 2'd3) begin
                        n_prefix_shift = {e_shift[15:0], i_data_byte};
                        n_prefix_count = e_count + 2'd1;
                    end else begin
                        n_prefix_count = 2'd0;
                        n_prefix_shift = 24'd0;
                        if (overrun) begin
                            n_phase = lpsc_pkg::PH_DISCARD;
                        end else begin
                            n_payload_left = unit_len;
                            n_phase = (unit_len == '0) ? lpsc_pkg::PH_PREFIX
                                                       : lpsc_pkg::PH_PAYLOAD;
                        end
                    end
                end
            end
            lpsc_pkg::PH_PAYLOAD: begin
                if ((e_buffer == '0) || (e_payload == '0)) begin
                    n_phase = lpsc_pkg::PH_DISCARD;
                end else begin
                    n_buffer_left  = buffer_dec;
                    n_payload_left = e_payload - lpsc_pkg::UNIT_LEN_W'(1);
                    if (e_payload == lpsc_pkg::UNIT_LEN_W'(1)) begin
                        n_phase = lpsc_pkg::PH_PREFIX;
                    end
                end
            end
            default: begin
                // discard and the unused code: bytes are dropped
                n_phase = lpsc_pkg::PH_DISCARD;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        o_burst.emit     = 1'b0;
        o_burst.is_start = 1'b0;
        o_burst.data     = i_data_byte;
        unique case (e_phase)
            lpsc_pkg::PH_PREFIX: begin
                if (!short_tail && (e_count == 2'd3) && !overrun) begin
                    o_burst.emit     = i_accept;
                    o_burst.is_start = 1'b1;
                end
            end
            lpsc_pkg::PH_PAYLOAD: begin
                if ((e_buffer != '0) && (e_payload != '0)) begin
                    o_burst.emit = i_accept;
                end
            end
            default: begin
                o_burst.emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= lpsc_pkg::PH_DISCARD;
            r_prefix_count <= 2'd0;
            r_prefix_shift <= 24'd0;
            r_payload_left <= '0;
            r_buffer_left  <= '0;
        end else if (i_accept) begin
            r_phase        <= n_phase;
            r_prefix_count <= n_prefix_count;
            r_prefix_shift <= n_prefix_shift;
            r_payload_left <= n_payload_left;
            r_buffer_left  <= n_buffer_left;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/lpsc_emit.sv
// ----------------------------------------------------------------------------
// lpsc_emit
// Output register: one payload beat or the four-beat start code burst.
// ----------------------------------------------------------------------------
`default_nettype none

module lpsc_emit (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire lpsc_pkg::t_burst i_burst,
    output logic                  o_load_ok,
    output logic                  o_m_axis_tvalid,
    input  wire logic             i_m_axis_tready,
    output logic [7:0]            o_m_axis_tdata,
    output logic                  o_m_axis_tuser,
    output logic                  o_m_axis_tlast
);

    logic       r_valid;
    logic       r_is_start;
    logic [1:0] r_beat;
    logic [7:0] r_data;
    logic       last_beat;

    assign last_beat = !r_is_start || (r_beat == 2'd3);
    // Free now, or freed by the final beat going out this cycle.
    assign o_load_ok = !r_valid || (i_m_axis_tready && last_beat);

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = r_is_start ? {7'd0, (r_beat == 2'd3)} : r_data;
    assign o_m_axis_tuser  = r_is_start && (r_beat == 2'd0);
    assign o_m_axis_tlast  = last_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_is_start <= 1'b0;
            r_beat     <= 2'd0;
        end else if (o_load_ok) begin
            r_valid    <= i_burst.emit;
            r_is_start <= i_burst.is_start;
            r_beat     <= 2'd0;
        end else if (i_m_axis_tready) begin
            r_beat <= r_beat + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load_ok && i_burst.emit) begin
            r_data <= i_burst.data;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/length_prefix_to_start_code_core.sv
// ----------------------------------------------------------------------------
// length_prefix_to_start_code_core
// Converts length-prefixed units of a sample buffer into a start-code stream.
// ----------------------------------------------------------------------------
// Results of an accepted byte are loaded into the output register on the
// accepting edge and appear on the master side from there.
// Throughput: one byte per cycle unless the master side stalls; a completed prefix
// drives a four-beat start code from the output register, holding the input to its last beat.
// Reset: synchronous, active low; parser returns to discard, output empties.
`default_nettype none

module length_prefix_to_start_code_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave side
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,  // [7:0] data_byte, [31:8] buffer_length
    input  wire logic        i_s_axis_tuser,  // [0] first_of_buffer
    // master side
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [7:0]       o_m_axis_tdata,  // [7:0] out_byte
    output logic             o_m_axis_tuser,  // [0] unit_start
    output logic             o_m_axis_tlast   // last_of_run
);

    lpsc_pkg::t_burst burst;
    logic             load_ok;
    logic             accept;

    // A byte is taken whenever the output register can hold its results,
    // including the cycle in which the last waiting beat leaves.
    assign o_s_axis_tready = load_ok;
    assign accept          = i_s_axis_tvalid && load_ok;

    // Parse state advances once per accepted byte; results go straight into
    // the output register on the same edge.
    lpsc_parser u_parser (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_data_byte       (i_s_axis_tdata[7:0]),
        .i_first_of_buffer (i_s_axis_tuser),
        .i_buffer_length   (i_s_axis_tdata[31:8]),
        .o_burst           (burst)
    );

    // Output register and start code sequencer.
    lpsc_emit u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_burst         (burst),
        .o_load_ok       (load_ok),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // A start code opens with a zero byte and is never the last beat.
    a_start_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |->
            (o_m_axis_tdata == 8'd0) && !o_m_axis_tlast)
        else $error("unit start beat malformed");

    // After the first start-code beat leaves, the burst continues.
    a_start_cont : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tuser) |=>
            o_m_axis_tvalid && !o_m_axis_tuser && (o_m_axis_tdata == 8'd0))
        else $error("start code burst broken");

    // Input is held back only while results are pending.
    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("input stalled with empty output");

endmodule

`default_nettype wire

// File: tb/length_prefix_to_start_code_core_tb.sv
// ----------------------------------------------------------------------------
// length_prefix_to_start_code_core_tb
// Self-checking bench for the length-prefix to start-code converter. Sample
// buffers are streamed in byte by byte under random source gaps and sink
// backpressure. A scoreboard tracks the converter state, builds the expected
// output beats and checks every beat leaving the master side, in order.
// ----------------------------------------------------------------------------

module length_prefix_to_start_code_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ITEM_TARGET = 210;
    localparam int unsigned HOLD_AT     = 70;   // sink holds off after this many beats in
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned CALM_FROM   = 130;  // window with no gaps on either side
    localparam int unsigned CALM_TO     = 175;
    localparam int unsigned STALL_LIMIT = 3000; // idle cycles before declaring a hang
    localparam int unsigned DRAIN_WAIT  = 8;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       last;
    } t_out_beat;

    // Tracks the parser state and holds the beats still owed on the master side.
    class start_code_scoreboard;
        lpsc_pkg::t_phase phase;
        logic [1:0]       prefix_cnt;
        logic [23:0]      prefix_acc;
        logic [31:0]      unit_left;
        logic [31:0]      buf_left;
        t_out_beat        owed_beats[$];
        int unsigned      errors;

        function void reset_state();
            phase      = lpsc_pkg::PH_DISCARD;
            prefix_cnt = '0;
            prefix_acc = '0;
            unit_left  = '0;
            buf_left   = '0;
            owed_beats.delete();
            errors     = 0;
        endfunction

        function void owe(logic [7:0] data, logic start, logic last);
            t_out_beat beat;
            beat.data  = data;
            beat.start = start;
            beat.last  = last;
            owed_beats = {owed_beats, beat};
        endfunction

        // Accepted slave beat: advance the state, queue what it produces.
        function void note_byte(logic [7:0] b, logic first,
                                logic [lpsc_pkg::BUF_LEN_W-1:0] blen);
            logic [63:0] len_mask;
            logic [31:0] unit_len;
            len_mask = (64'd1 << lpsc_pkg::LENGTH_BITS) - 64'd1;
            if (first) begin
                buf_left   = 32'(64'(blen) & len_mask);
                phase      = lpsc_pkg::PH_PREFIX;
                prefix_cnt = '0;
                prefix_acc = '0;
                unit_left  = '0;
            end
            case (phase)
                lpsc_pkg::PH_PREFIX: begin
                    // a prefix needs four bytes left, this one included
                    if (prefix_cnt == 0 && buf_left < lpsc_pkg::PREFIX_BYTES) begin
                        phase = lpsc_pkg::PH_DISCARD;
                    end else begin
                        buf_left = buf_left - 1;
                        if (prefix_cnt < 3) begin
                            prefix_acc = {prefix_acc[15:0], b};
                            prefix_cnt = prefix_cnt + 2'd1;
                        end else begin
                            unit_len   = {prefix_acc, b};
                            prefix_cnt = '0;
                            prefix_acc = '0;
                            if (unit_len > buf_left) begin
                                // unit overruns the buffer: drop the rest
                                phase = lpsc_pkg::PH_DISCARD;
                            end else begin
                                owe(8'h00, 1'b1, 1'b0);
                                owe(8'h00, 1'b0, 1'b0);
                                owe(8'h00, 1'b0, 1'b0);
                                owe(8'h01, 1'b0, 1'b1);
                                unit_left = unit_len;
                                phase = (unit_len == 0) ? lpsc_pkg::PH_PREFIX
                                                        : lpsc_pkg::PH_PAYLOAD;
                            end
                        end
                    end
                end
                lpsc_pkg::PH_PAYLOAD: begin
                    if (buf_left == 0 || unit_left == 0) begin
                        phase = lpsc_pkg::PH_DISCARD;
                    end else begin
                        buf_left  = buf_left - 1;
                        unit_left = unit_left - 1;
                        if (unit_left == 0) phase = lpsc_pkg::PH_PREFIX;
                        owe(b, 1'b0, 1'b1);
                    end
                end
                default: ;
            endcase
        endfunction

        task report(string what, logic [7:0] exp_v, logic [7:0] got_v);
            $display("[%0t] mismatch on %s: expected 0x%02h, got 0x%02h",
                     $realtime, what, exp_v, got_v);
            errors++;
        endtask

        // Accepted master beat: compare against the oldest owed beat.
        task check_beat(logic [7:0] data, logic start, logic last);
            t_out_beat exp_beat;
            if (owed_beats.size() == 0) begin
                report("unexpected beat", 8'h00, data);
            end else begin
                exp_beat = owed_beats.pop_front();
                if (data !== exp_beat.data)   report("out_byte", exp_beat.data, data);
                if (start !== exp_beat.start) report("unit_start", 8'(exp_beat.start), 8'(start));
                if (last !== exp_beat.last)   report("last_of_run", 8'(exp_beat.last), 8'(last));
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata  = '0;  // [7:0] data_byte, [31:8] buffer_length
    logic        i_s_axis_tuser  = 1'b0; // [0] first_of_buffer
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [7:0]  o_m_axis_tdata;        // [7:0] out_byte
    logic        o_m_axis_tuser;        // [0] unit_start
    logic        o_m_axis_tlast;        // last_of_run

    start_code_scoreboard sb;
    int unsigned beats_in = 0;
    bit          calm     = 1'b0;
    bit          held     = 1'b0;
    logic [7:0]  buf_bytes[$];          // bytes of the buffer being assembled

    length_prefix_to_start_code_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Both handshakes sampled at the edge, before any update from it lands.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                sb.note_byte(i_s_axis_tdata[7:0], i_s_axis_tuser, i_s_axis_tdata[31:8]);
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_beat(o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
        end
    end

    // Sink: random backpressure, one long hold-off once the stream is going,
    // and none at all inside the calm window.
    initial begin
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (!held && beats_in >= HOLD_AT) begin
                held = 1'b1;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 36);
            end
        end
    end

    // Hang detector: cycles in which neither side moves a beat.
    initial begin
        int unsigned quiet;
        quiet = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    // One slave beat, with a random gap in front unless in the calm window.
    task drive_byte(logic [7:0] b, logic first, logic [23:0] blen);
        while (!calm && $urandom_range(99) < 36) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {blen, b};
        i_s_axis_tuser  <= first;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        beats_in++;
        calm = (beats_in >= CALM_FROM && beats_in < CALM_TO);
    endtask

    task add_byte(logic [7:0] b);
        buf_bytes = {buf_bytes, b};
    endtask

    task push_prefix(logic [31:0] len);
        add_byte(len[31:24]);
        add_byte(len[23:16]);
        add_byte(len[15:8]);
        add_byte(len[7:0]);
    endtask

    task push_unit(int unsigned len);
        push_prefix(len);
        repeat (len) add_byte(8'($urandom));
    endtask

    // Streams the assembled buffer; the length field rides on the first byte
    // only, the rest carry junk there.
    task send_buffer(logic [23:0] blen);
        foreach (buf_bytes[i])
            drive_byte(buf_bytes[i], i == 0, (i == 0) ? blen : 24'($urandom));
        buf_bytes.delete();
    endtask

    function automatic int unsigned pick_unit_len();
        return ($urandom_range(9) == 0) ? $urandom_range(30) : $urandom_range(6);
    endfunction

    task random_buffer();
        int unsigned kind;
        int unsigned spare;
        kind = $urandom_range(99);
        if (kind < 70) begin
            // well-formed units, optionally a short tail or a cut-off length
            repeat ($urandom_range(1, 3)) push_unit(pick_unit_len());
            repeat ($urandom_range(3)) add_byte(8'($urandom));
            if ($urandom_range(9) == 0)
                send_buffer(24'($urandom_range(1, buf_bytes.size())));
            else
                send_buffer(24'(buf_bytes.size()));
        end else if (kind < 80) begin
            // last unit claims more than the buffer holds
            if ($urandom_range(1)) push_unit(pick_unit_len());
            spare = $urandom_range(4);
            if ($urandom_range(3) == 0)
                push_prefix($urandom | 32'h8000_0000);
            else
                push_prefix(spare + 1 + $urandom_range(1000));
            repeat (spare) add_byte(8'($urandom));
            send_buffer(24'(buf_bytes.size()));
        end else if (kind < 87) begin
            // huge declared length, cut short by the next buffer
            repeat ($urandom_range(1, 2)) push_unit(pick_unit_len());
            send_buffer(24'($urandom) | 24'h80_0000);
        end else if (kind < 93) begin
            // zero-length buffer: everything up to the next start dropped
            repeat ($urandom_range(1, 5)) push_unit(pick_unit_len());
            send_buffer(24'd0);
        end else begin
            // stray bytes with no buffer start
            repeat ($urandom_range(1, 6)) drive_byte(8'($urandom), 1'b0, 24'($urandom));
        end
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // bytes before any buffer start
        drive_byte(8'hAA, 1'b0, 24'h12_3456);
        // zero buffer length, then a byte past it
        drive_byte(8'h00, 1'b1, 24'd0);
        drive_byte(8'h55, 1'b0, 24'hED_CBA9);
        // empty unit: start code alone
        push_prefix(32'd0);
        send_buffer(24'd4);
        // one-byte unit at full scale, then a short tail that is dropped
        push_prefix(32'd1);
        add_byte(8'hFF);
        repeat (3) add_byte(8'h00);
        send_buffer(24'd8);
        // unit longer than what is left
        push_prefix(32'd5);
        add_byte(8'h11);
        add_byte(8'h22);
        send_buffer(24'd6);
        // largest prefix against the largest buffer length
        push_prefix(32'hFFFF_FFFF);
        send_buffer(24'hFF_FFFF);

        while (beats_in < ITEM_TARGET) random_buffer();
        i_s_axis_tvalid <= 1'b0;

        while (sb.owed_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
